FILE: design/utpp_pkg.sv
// utpp_pkg: types and constants shared by the uTP packet header parser
// used by utpp_parser and utp_packet_header_parser_unit; no dependencies

package utpp_pkg;

   // fixed header length in bytes
   localparam int HDR_BYTES = 20;

   // widths of the item fields
   localparam int BYTE_W   = 8;
   localparam int ROLE_W   = 3;
   localparam int TYPE_W   = 4;
   localparam int WORD_W   = 16;
   localparam int OFFSET_W = 13;

   // parse position inside a packet
   typedef enum logic [2:0] {
      PH_HEADER,
      PH_EXT_ID,
      PH_EXT_LEN,
      PH_EXT_BODY,
      PH_PAYLOAD
   } phase_type;

   // tag given to each byte
   typedef enum logic [ROLE_W-1:0] {
      ROLE_HEADER,
      ROLE_EXT_ID,
      ROLE_EXT_LEN,
      ROLE_SACK_MASK,
      ROLE_EXT_BODY,
      ROLE_PAYLOAD
   } role_type;

   // one result item
   typedef struct packed {
      logic [BYTE_W-1:0]   byte_out;
      role_type            role;
      logic                last_out;
      logic                packet_ok;
      logic [TYPE_W-1:0]   packet_type;
      logic [WORD_W-1:0]   conn_id;
      logic [WORD_W-1:0]   seq_number;
      logic [WORD_W-1:0]   ack_number;
      logic                sack_present;
      logic [BYTE_W-1:0]   sack_len;
      logic [OFFSET_W-1:0] payload_offset;
      logic [OFFSET_W-1:0] payload_size;
   } result_type;

endpackage

FILE: design/utp_packet_header_parser_unit.sv
// utp_packet_header_parser_unit: stream top level of the uTP header parser
// depends on utpp_pkg and utpp_parser
//
// Usage: packet bytes enter on the req_ channel, one item per byte, with
// req_tlast on the final byte of a packet. For every byte one item leaves
// on the rsp_ channel: the byte itself, its role in rsp_tuser, and on the
// final byte (rsp_tlast) the packet summary in the upper tdata bits.
// csr_ writes the selective-ack extension id and is always ready; the user must
// write it only while no packet byte is in flight; the block does not check.
// Each accepted item sits in the input register, then moves into the result
// register, which drives rsp_tvalid. Throughput: one byte per cycle while
// rsp_tready stays high, set by the combinational parse step between the
// two registers.
// Reset (synchronous, active high) empties both registers, sets the
// selective-ack id to 1 and starts a new packet at the header.
// When the receiver stalls, the result register holds; the input register
// takes one more item, then req_tready falls until rsp_tready returns.

module utp_packet_header_parser_unit
   import utpp_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tlast,   // is_last
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // byte_out, packet_ok, packet_type, conn_id,
                                    // seq_number, ack_number, sack_present,
                                    // sack_len, payload_offset, payload_size
   output logic [2:0]  rsp_tuser,   // role
   output logic        rsp_tlast,   // last_out
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // sack_ext_id
);

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              rsp_valid_ff;
   result_type        rsp_ff;
   logic [BYTE_W-1:0] sack_id_ff;
   logic              advance;
   result_type        result;

   // input register moves on when the result register is free
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         sack_id_ff <= BYTE_W'(1);
      end else if (csr_valid) begin
         sack_id_ff <= csr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   utpp_parser #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .byte_value  (in_byte_ff),
      .is_last     (in_last_ff),
      .sack_ext_id (sack_id_ff),
      .result      (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   // pack the result item
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.role;
   assign rsp_tlast  = rsp_ff.last_out;
   assign rsp_tdata  = {rsp_ff.payload_size, rsp_ff.payload_offset, rsp_ff.sack_len,
                        rsp_ff.sack_present, rsp_ff.ack_number, rsp_ff.seq_number,
                        rsp_ff.conn_id, rsp_ff.packet_type, rsp_ff.packet_ok,
                        rsp_ff.byte_out};

endmodule

FILE: design/utpp_parser.sv
// utpp_parser: per-packet parse state and the single-pass byte classifier
// depends on utpp_pkg

module utpp_parser
   import utpp_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] byte_value,
   input  logic              is_last,
   input  logic [BYTE_W-1:0] sack_ext_id,
   output result_type        result
);

   // byte counter saturates at the packet limit; data start can run past it
   localparam int CW = $clog2(MAX_PACKET_BYTES + 1);
   localparam int DW = $clog2(MAX_PACKET_BYTES + 257);

   logic [CW-1:0]     count_ff, count_in;
   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] next_id_ff, next_id_in;
   logic [BYTE_W-1:0] left_ff, left_in;
   logic              cur_sack_ff, cur_sack_in;
   logic              sack_seen_ff, sack_seen_in;
   logic [BYTE_W-1:0] sack_len_ff, sack_len_in;
   logic [DW-1:0]     data_start_ff, data_start_in;
   logic              error_ff, error_in;
   logic [TYPE_W-1:0] type_ff, type_in;
   logic [WORD_W-1:0] conn_ff, conn_in;
   logic [WORD_W-1:0] seq_ff, seq_in;
   logic [WORD_W-1:0] ack_ff, ack_in;

   // next state and result for the byte in hand
   always_comb begin
      logic [CW-1:0]     idx;
      logic [DW-1:0]     size;
      logic [BYTE_W-1:0] left_dec;
      phase_type         after_ext;
      role_type          role;
      logic              ok;

      idx       = count_ff;
      size      = DW'(idx) + DW'(1);
      left_dec  = left_ff - BYTE_W'(1);
      after_ext = (next_id_ff != '0) ? PH_EXT_ID : PH_PAYLOAD;
      role      = ROLE_HEADER;

      count_in      = count_ff;
      phase_in      = phase_ff;
      next_id_in    = next_id_ff;
      left_in       = left_ff;
      cur_sack_in   = cur_sack_ff;
      sack_seen_in  = sack_seen_ff;
      sack_len_in   = sack_len_ff;
      data_start_in = data_start_ff;
      error_in      = error_ff | (idx >= CW'(MAX_PACKET_BYTES));
      type_in       = type_ff;
      conn_in       = conn_ff;
      seq_in        = seq_ff;
      ack_in        = ack_ff;

      case (phase_ff)
         PH_HEADER: begin
            role = ROLE_HEADER;
            if (idx == CW'(0)) type_in = byte_value[7:4];
            if (idx == CW'(1)) next_id_in = byte_value;
            if (idx == CW'(2)) conn_in[15:8] = byte_value;
            if (idx == CW'(3)) conn_in[7:0] = byte_value;
            if (idx == CW'(16)) seq_in[15:8] = byte_value;
            if (idx == CW'(17)) seq_in[7:0] = byte_value;
            if (idx == CW'(18)) ack_in[15:8] = byte_value;
            if (idx == CW'(HDR_BYTES - 1)) begin
               ack_in[7:0]   = byte_value;
               data_start_in = DW'(HDR_BYTES);
               phase_in      = after_ext;
            end
         end
         PH_EXT_ID: begin
            role        = ROLE_EXT_ID;
            cur_sack_in = (next_id_ff == sack_ext_id);
            if (next_id_ff == sack_ext_id) sack_seen_in = 1'b1;
            next_id_in  = byte_value;
            phase_in    = PH_EXT_LEN;
         end
         PH_EXT_LEN: begin
            role    = ROLE_EXT_LEN;
            left_in = byte_value;
            if (cur_sack_ff) sack_len_in = byte_value;
            data_start_in = size + DW'(byte_value);
            phase_in = (byte_value == '0) ? after_ext : PH_EXT_BODY;
         end
         PH_EXT_BODY: begin
            role    = cur_sack_ff ? ROLE_SACK_MASK : ROLE_EXT_BODY;
            left_in = left_dec;
            if (left_dec == '0) phase_in = after_ext;
         end
         default: begin
            role = ROLE_PAYLOAD;
         end
      endcase

      if (idx < CW'(MAX_PACKET_BYTES)) count_in = count_ff + CW'(1);

      // packet summary on the final byte
      ok = !error_in && (size >= DW'(HDR_BYTES)) && (phase_in != PH_EXT_LEN)
           && (phase_in != PH_EXT_BODY) && (data_start_in <= size);

      result          = '0;
      result.byte_out = byte_value;
      result.role     = role;
      result.last_out = is_last;
      if (is_last) begin
         result.packet_ok    = ok;
         result.packet_type  = type_in;
         result.conn_id      = conn_in;
         result.seq_number   = seq_in;
         result.ack_number   = ack_in;
         result.sack_present = sack_seen_in;
         result.sack_len     = sack_len_in;
         if (ok) begin
            result.payload_offset = OFFSET_W'(data_start_in);
            result.payload_size   = OFFSET_W'(size - data_start_in);
         end
      end
   end

   // parse state, cleared after the final byte of each packet
   always_ff @(posedge clock) begin
      if (reset || (step && is_last)) begin
         count_ff      <= '0;
         phase_ff      <= PH_HEADER;
         next_id_ff    <= '0;
         left_ff       <= '0;
         cur_sack_ff   <= 1'b0;
         sack_seen_ff  <= 1'b0;
         sack_len_ff   <= '0;
         data_start_ff <= '0;
         error_ff      <= 1'b0;
         type_ff       <= '0;
         conn_ff       <= '0;
         seq_ff        <= '0;
         ack_ff        <= '0;
      end else if (step) begin
         count_ff      <= count_in;
         phase_ff      <= phase_in;
         next_id_ff    <= next_id_in;
         left_ff       <= left_in;
         cur_sack_ff   <= cur_sack_in;
         sack_seen_ff  <= sack_seen_in;
         sack_len_ff   <= sack_len_in;
         data_start_ff <= data_start_in;
         error_ff      <= error_in;
         type_ff       <= type_in;
         conn_ff       <= conn_in;
         seq_ff        <= seq_in;
         ack_ff        <= ack_in;
      end
   end

endmodule

FILE: verif/tb_utp_packet_header_parser_unit.sv
// tb_utp_packet_header_parser_unit: stream testbench of the uTP header parser
// needs utpp_pkg and utp_packet_header_parser_unit; self-checking, no files read

`timescale 1ns / 1ps

module tb_utp_packet_header_parser_unit;
   import utpp_pkg::*;

   localparam int MAX_PACKET_BYTES = 4096;

   // one packet byte waiting to be sent
   typedef struct {
      logic [7:0] value;
      logic       last;
   } byte_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] byte_value
   logic        req_tlast = 1'b0;   // is_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;          // byte_out, packet_ok, packet_type, conn_id,
                                    // seq_number, ack_number, sack_present,
                                    // sack_len, payload_offset, payload_size
   logic [2:0]  rsp_tuser;          // role
   logic        rsp_tlast;          // last_out
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = 8'd0;    // sack_ext_id

   byte_item_type bytes_to_send [$];
   result_type  results_due [$];
   int          bytes_in_flight = 0;
   int          items_queued = 0;
   int          results_checked = 0;
   int          mismatches = 0;
   int          packets_seen = 0;
   int          packets_clean = 0;
   int          sack_packets = 0;
   int          idle_pct = 29;
   bit          req_accepted = 1'b0;

   // parser state as the block should hold it
   logic [7:0]  sack_id = 8'd1;
   int          pkt_count;
   phase_type   pkt_phase;
   logic [7:0]  chain_id;
   logic [7:0]  body_left;
   bit          in_sack;
   bit          sack_flag;
   logic [7:0]  sack_len_q;
   int          data_start_q;
   bit          err_q;
   logic [3:0]  type_q;
   logic [15:0] conn_q;
   logic [15:0] seq_q;
   logic [15:0] ack_q;

   utp_packet_header_parser_unit #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // fresh packet: start again at the header
   function automatic void clear_packet_state();
      pkt_count = 0;
      pkt_phase = PH_HEADER;
      chain_id = 8'd0;
      body_left = 8'd0;
      in_sack = 1'b0;
      sack_flag = 1'b0;
      sack_len_q = 8'd0;
      data_start_q = 0;
      err_q = 1'b0;
      type_q = 4'd0;
      conn_q = 16'd0;
      seq_q = 16'd0;
      ack_q = 16'd0;
   endfunction

   // where the chain goes once an extension (or the header) is done
   function automatic phase_type chain_next();
      if (chain_id != 8'd0)
         return PH_EXT_ID;
      return PH_PAYLOAD;
   endfunction

   // tag one byte and, on the final byte, summarise the packet
   function automatic result_type parse_byte(logic [7:0] b, logic last);
      result_type r;
      int idx;
      int size;
      bit ok;
      r = '0;
      idx = pkt_count;
      if (idx >= MAX_PACKET_BYTES)
         err_q = 1'b1;
      r.role = ROLE_HEADER;
      case (pkt_phase)
         PH_HEADER: begin
            case (idx)
               0:  type_q = b[7:4];
               1:  chain_id = b;
               2:  conn_q[15:8] = b;
               3:  conn_q[7:0] = b;
               16: seq_q[15:8] = b;
               17: seq_q[7:0] = b;
               18: ack_q[15:8] = b;
               19: ack_q[7:0] = b;
               default: ;
            endcase
            if (idx == HDR_BYTES - 1) begin
               data_start_q = HDR_BYTES;
               pkt_phase = chain_next();
            end
         end
         PH_EXT_ID: begin
            r.role = ROLE_EXT_ID;
            in_sack = (chain_id == sack_id);
            if (in_sack)
               sack_flag = 1'b1;
            chain_id = b;
            pkt_phase = PH_EXT_LEN;
         end
         PH_EXT_LEN: begin
            r.role = ROLE_EXT_LEN;
            body_left = b;
            if (in_sack)
               sack_len_q = b;
            data_start_q = idx + 1 + b;
            if (b == 8'd0)
               pkt_phase = chain_next();
            else
               pkt_phase = PH_EXT_BODY;
         end
         PH_EXT_BODY: begin
            r.role = in_sack ? ROLE_SACK_MASK : ROLE_EXT_BODY;
            body_left = body_left - 8'd1;
            if (body_left == 8'd0)
               pkt_phase = chain_next();
         end
         default: r.role = ROLE_PAYLOAD;
      endcase
      if (pkt_count < MAX_PACKET_BYTES)
         pkt_count++;
      r.byte_out = b;
      r.last_out = last;
      if (last) begin
         size = idx + 1;
         ok = !err_q && size >= HDR_BYTES && pkt_phase != PH_EXT_LEN &&
              pkt_phase != PH_EXT_BODY && data_start_q <= size;
         r.packet_ok = ok;
         r.packet_type = type_q;
         r.conn_id = conn_q;
         r.seq_number = seq_q;
         r.ack_number = ack_q;
         r.sack_present = sack_flag;
         r.sack_len = sack_len_q;
         if (ok) begin
            r.payload_offset = 13'(data_start_q);
            r.payload_size = 13'(size - data_start_q);
         end
         packets_seen++;
         if (ok)
            packets_clean++;
         if (sack_flag)
            sack_packets++;
         clear_packet_state();
      end
      return r;
   endfunction

   // report one differing field, only for the first few mismatches
   function automatic bit field_differs(string name, logic [15:0] got, logic [15:0] want);
      if (got === want)
         return 1'b0;
      if (mismatches < 10)
         $display("item %0d %s: expected %0h, got %0h", results_checked, name, want, got);
      return 1'b1;
   endfunction

   // sender: next item at the falling edge once the last one has gone
   always @(negedge clock) begin : driver
      byte_item_type item;
      rsp_tready <= !reset && ($urandom_range(99) >= idle_pct);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_accepted) begin
         if (bytes_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
            item = bytes_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= item.value;
            req_tlast <= item.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // handshakes at the rising edge: predict on input, check on output
   always @(posedge clock) begin : monitor
      result_type want;
      result_type got;
      bit bad;
      if (reset) begin
         clear_packet_state();
         sack_id = 8'd1;
         req_accepted = 1'b0;
      end else begin
         if (csr_valid && csr_ready)
            sack_id = csr_data;
         req_accepted = req_tvalid && req_tready;
         if (req_accepted)
            results_due.push_back(parse_byte(req_tdata, req_tlast));
         if (rsp_tvalid && rsp_tready) begin
            got.byte_out = rsp_tdata[7:0];
            got.role = role_type'(rsp_tuser);
            got.last_out = rsp_tlast;
            got.packet_ok = rsp_tdata[8];
            got.packet_type = rsp_tdata[12:9];
            got.conn_id = rsp_tdata[28:13];
            got.seq_number = rsp_tdata[44:29];
            got.ack_number = rsp_tdata[60:45];
            got.sack_present = rsp_tdata[61];
            got.sack_len = rsp_tdata[69:62];
            got.payload_offset = rsp_tdata[82:70];
            got.payload_size = rsp_tdata[95:83];
            if (results_due.size() == 0) begin
               if (mismatches < 10)
                  $display("result item with nothing pending: tdata %h", rsp_tdata);
               mismatches++;
            end else begin
               want = results_due.pop_front();
               bytes_in_flight--;
               bad = 1'b0;
               bad |= field_differs("byte_out", got.byte_out, want.byte_out);
               bad |= field_differs("role", got.role, want.role);
               bad |= field_differs("last_out", got.last_out, want.last_out);
               bad |= field_differs("packet_ok", got.packet_ok, want.packet_ok);
               bad |= field_differs("packet_type", got.packet_type, want.packet_type);
               bad |= field_differs("conn_id", got.conn_id, want.conn_id);
               bad |= field_differs("seq_number", got.seq_number, want.seq_number);
               bad |= field_differs("ack_number", got.ack_number, want.ack_number);
               bad |= field_differs("sack_present", got.sack_present, want.sack_present);
               bad |= field_differs("sack_len", got.sack_len, want.sack_len);
               bad |= field_differs("payload_offset", got.payload_offset,
                                    want.payload_offset);
               bad |= field_differs("payload_size", got.payload_size, want.payload_size);
               if (bad)
                  mismatches++;
               results_checked++;
            end
         end
      end
   end

   task automatic push_byte(logic [7:0] value, logic last);
      byte_item_type item;
      item.value = value;
      item.last = last;
      bytes_to_send.push_back(item);
      bytes_in_flight++;
      items_queued++;
   endtask

   // extension id: half the time the selective ack one, unless that id is zero
   function automatic logic [7:0] pick_ext_id();
      if (sack_id != 8'd0 && $urandom_range(1) == 0)
         return sack_id;
      return 8'($urandom_range(255, 1));
   endfunction

   // well-formed packet with random content, optionally cut short anywhere
   task automatic queue_packet(int n_ext, int pay_len, bit chop);
      logic [7:0] pkt [$];
      logic [7:0] ids [$];
      int len;
      int keep;
      for (int k = 0; k < n_ext; k++)
         ids.push_back(pick_ext_id());
      for (int k = 0; k < HDR_BYTES; k++)
         pkt.push_back(8'($urandom));
      pkt[1] = (n_ext > 0) ? ids[0] : 8'd0;
      for (int k = 0; k < n_ext; k++) begin
         pkt.push_back((k + 1 < n_ext) ? ids[k + 1] : 8'd0);
         len = ($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(12);
         pkt.push_back(8'(len));
         repeat (len) pkt.push_back(8'($urandom));
      end
      repeat (pay_len) pkt.push_back(8'($urandom));
      keep = chop ? $urandom_range(pkt.size(), 1) : pkt.size();
      for (int k = 0; k < keep; k++)
         push_byte(pkt[k], k == keep - 1);
   endtask

   // mostly proper packets, some truncated ones, some noise
   task automatic random_traffic(int n);
      int start;
      int pick;
      int len;
      start = items_queued;
      while (items_queued - start < n) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            queue_packet($urandom_range(3), $urandom_range(30), 1'b0);
         end else if (pick < 85) begin
            queue_packet($urandom_range(3), $urandom_range(10), 1'b1);
         end else begin
            len = $urandom_range(40, 1);
            for (int k = 0; k < len; k++)
               push_byte(8'($urandom), k == len - 1);
         end
      end
   endtask

   // idle point: every item answered, then a short pause
   task automatic drain();
      while (bytes_in_flight != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_sack_id(logic [7:0] id);
      csr_data <= id;
      csr_valid <= 1'b1;
      do
         @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: short packets and a header-only one with an extension announced
      push_byte(8'h00, 1'b1);
      for (int k = 0; k < HDR_BYTES; k++)
         push_byte(8'hFF, k == HDR_BYTES - 1);
      push_byte(8'hFF, 1'b1);
      random_traffic(330);
      drain();

      // highest id, no idling on either side
      write_sack_id(8'hFF);
      idle_pct = 0;
      random_traffic(350);
      drain();

      // id zero never matches
      idle_pct = 29;
      write_sack_id(8'h00);
      random_traffic(300);
      drain();

      // back to the reset id
      write_sack_id(8'h01);
      random_traffic(350);
      drain();

      // random id
      write_sack_id(8'($urandom_range(254, 2)));
      random_traffic(350);
      drain();

      repeat (10) @(negedge clock);
      if (results_due.size() != 0) begin
         $display("%0d result items never arrived", results_due.size());
         mismatches += results_due.size();
      end
      $display("%0d packets over %0d checked items: %0d clean, %0d with selective ack",
               packets_seen, results_checked, packets_clean, sack_packets);
      $display("selective ack ids 1, 255, 0, 1 and one random; short, cut and noise packets");
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("timeout with %0d items still in flight", bytes_in_flight);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: utp_packet_header_parser_unit.f
design/utpp_pkg.sv
design/utpp_parser.sv
design/utp_packet_header_parser_unit.sv
verif/tb_utp_packet_header_parser_unit.sv
